@@ sv/hvn_pkg.sv @@
// ----------------------------------------------------------------------------
// hvn_pkg
// shared types and constants for the wrapped heightfield vertex normal block
// ----------------------------------------------------------------------------
package hvn_pkg;

  // grid edge length, a power of two; coordinates wrap by masking
  localparam int GRID_SIZE = 128;
  localparam int GRID_BITS = $clog2(GRID_SIZE);
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;

  localparam int DISP_W  = 16;   // displacement, Q8.8
  localparam int COORD_W = 16;   // unwrapped grid coordinate
  localparam int DIFF_W  = 18;   // neighbor minus center, Q10.8
  localparam int NSUM_W  = 40;   // cross product sum
  localparam int POS_W   = 24;   // position, Q16.8
  localparam int NORM_W  = 16;   // normal, Q1.14
  localparam int PADDR_W = 4;

  // one grid step is 2.0 in Q10.8
  localparam logic signed [DIFF_W-1:0] STEP = DIFF_W'(512);

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_PATCH_SIZE = 2'd0,
    REG_PATCH_COL  = 2'd1,
    REG_PATCH_ROW  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        [6:0] patch_size;
    logic signed [7:0] patch_col;
    logic signed [7:0] patch_row;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
  } res_t;

endpackage

@@ sv/hvn_ram.sv @@
// ----------------------------------------------------------------------------
// hvn_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/hvn_core.sv @@
// ----------------------------------------------------------------------------
// hvn_core
// grid store and sequencer: neighbor reads, cross products on one shared
// multiplier, normalization, bit-serial square root and division
// ----------------------------------------------------------------------------
module hvn_core import hvn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  logic [6:0]        col,
  input  logic [6:0]        row,
  input  logic [DISP_W-1:0] disp_x,
  input  logic [DISP_W-1:0] disp_y,
  input  logic [DISP_W-1:0] disp_z,
  input  cfg_t              cfg,
  output logic              ready,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CROSS, S_ABS, S_NORM, S_SQR, S_SQRT, S_DIVS, S_DIV, S_DONE
  } state_t;

  localparam int AW = 2 * GRID_BITS;

  state_t state;
  logic [3:0] step;
  logic [4:0] cnt;
  logic [1:0] di;

  logic signed [COORD_W-1:0] cx, cy;
  logic signed [DISP_W-1:0]  pd [3];
  logic signed [DIFF_W-1:0]  de [3], ds [3], dw [3], dn [3];
  logic signed [NSUM_W-1:0]  nsum [3];
  logic        [NSUM_W-1:0]  mag [3];
  logic                      neg [3];
  logic        [63:0]        sum;
  logic        [63:0]        rad;
  logic        [33:0]        srem;
  logic        [31:0]        root;
  logic        [31:0]        drem;
  logic        [14:0]        dnum;
  logic        [14:0]        quo;

  // ram
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [3*DISP_W-1:0]    wdata, rdata;

  hvn_ram #(.WIDTH(3 * DISP_W), .DEPTH(CELLS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign we    = start && !op;
  assign waddr = {GRID_BITS'(row), GRID_BITS'(col)};
  assign wdata = {disp_z, disp_y, disp_x};

  // neighbor address, wrapped by masking
  logic [GRID_BITS-1:0] wx, wy;
  always_comb begin
    wx = cx[GRID_BITS-1:0];
    wy = cy[GRID_BITS-1:0];
    case (step)
      4'd1:    wx = wx + GRID_BITS'(1);
      4'd2:    wy = wy + GRID_BITS'(1);
      4'd3:    wx = wx - GRID_BITS'(1);
      4'd4:    wy = wy - GRID_BITS'(1);
      default: ;
    endcase
    raddr = {wy, wx};
  end

  // patch origin plus offset
  logic signed [COORD_W-1:0] org_x, org_y;
  assign org_x = $signed(cfg.patch_col) * $signed({1'b0, cfg.patch_size});
  assign org_y = $signed(cfg.patch_row) * $signed({1'b0, cfg.patch_size});

  function automatic logic signed [DIFF_W-1:0] dsub(
    input logic signed [DISP_W-1:0] q,
    input logic signed [DISP_W-1:0] p,
    input logic signed [DIFF_W-1:0] off
  );
    return DIFF_W'(q) - DIFF_W'(p) + off;
  endfunction

  logic signed [DISP_W-1:0] qx, qy, qz;
  assign qx = rdata[DISP_W-1:0];
  assign qy = rdata[2*DISP_W-1:DISP_W];
  assign qz = rdata[3*DISP_W-1:2*DISP_W];

  // shared multiplier operand select
  logic signed [31:0] ma, mb;
  logic signed [63:0] mul_p;
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_CROSS) begin
      case (step)
        4'd0:  begin ma = 32'(de[1]); mb = 32'(ds[2]); end
        4'd1:  begin ma = 32'(de[2]); mb = 32'(ds[1]); end
        4'd2:  begin ma = 32'(dw[1]); mb = 32'(dn[2]); end
        4'd3:  begin ma = 32'(dw[2]); mb = 32'(dn[1]); end
        4'd4:  begin ma = 32'(de[2]); mb = 32'(ds[0]); end
        4'd5:  begin ma = 32'(de[0]); mb = 32'(ds[2]); end
        4'd6:  begin ma = 32'(dw[2]); mb = 32'(dn[0]); end
        4'd7:  begin ma = 32'(dw[0]); mb = 32'(dn[2]); end
        4'd8:  begin ma = 32'(de[0]); mb = 32'(ds[1]); end
        4'd9:  begin ma = 32'(de[1]); mb = 32'(ds[0]); end
        4'd10: begin ma = 32'(dw[0]); mb = 32'(dn[1]); end
        4'd11: begin ma = 32'(dw[1]); mb = 32'(dn[0]); end
        default: ;
      endcase
    end else if (state == S_SQR && step < 4'd3) begin
      ma = $signed({1'b0, mag[step[1:0]][30:0]});
      mb = ma;
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= ma * mb;
  end

  // accumulate index for the product that just left the multiplier
  logic [3:0] acc_j;
  logic signed [NSUM_W-1:0] prod;
  assign acc_j = step - 4'd1;
  assign prod  = mul_p[NSUM_W-1:0];

  logic [NSUM_W-1:0] mor;
  assign mor = mag[0] | mag[1] | mag[2];

  // square root step, two radicand bits per cycle
  logic [35:0] st, strial;
  assign st     = {srem, rad[63:62]};
  assign strial = {2'b00, root, 2'b01};

  // division step, one quotient bit per cycle
  logic [32:0] dr;
  logic [45:0] dn_init;
  logic        qbit;
  logic [14:0] qn;
  logic signed [NORM_W-1:0] qv;
  assign dr      = {drem, dnum[14]};
  assign qbit    = dr >= {1'b0, root};
  assign qn      = {quo[13:0], qbit};
  assign qv      = neg[di] ? -$signed(NORM_W'(qn)) : $signed(NORM_W'(qn));
  assign dn_init = {1'b0, mag[di][30:0], 14'b0} + 46'(root[31:1]);

  assign ready     = state == S_IDLE;
  assign res_valid = state == S_DONE;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      cnt   <= '0;
      di    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && op) begin
            cx   <= org_x + COORD_W'(col);
            cy   <= org_y + COORD_W'(row);
            step <= '0;
            res.norm_x     <= '0;
            res.norm_y     <= '0;
            res.norm_z     <= '0;
            res.degenerate <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          case (step)
            4'd1: begin pd[0] <= qx; pd[1] <= qy; pd[2] <= qz; end
            4'd2: begin
              de[0] <= dsub(qx, pd[0], STEP);
              de[1] <= dsub(qy, pd[1], '0);
              de[2] <= dsub(qz, pd[2], '0);
            end
            4'd3: begin
              ds[0] <= dsub(qx, pd[0], '0);
              ds[1] <= dsub(qy, pd[1], STEP);
              ds[2] <= dsub(qz, pd[2], '0);
            end
            4'd4: begin
              dw[0] <= dsub(qx, pd[0], -STEP);
              dw[1] <= dsub(qy, pd[1], '0);
              dw[2] <= dsub(qz, pd[2], '0);
            end
            4'd5: begin
              dn[0] <= dsub(qx, pd[0], '0);
              dn[1] <= dsub(qy, pd[1], -STEP);
              dn[2] <= dsub(qz, pd[2], '0);
            end
            default: ;
          endcase
          if (step == 4'd5) begin
            step <= '0;
            nsum[0] <= '0;
            nsum[1] <= '0;
            nsum[2] <= '0;
            res.pos_x <= POS_W'(pd[0]) + {cx[14:0], 9'b0};
            res.pos_y <= POS_W'(pd[1]) + {cy[14:0], 9'b0};
            res.pos_z <= POS_W'(pd[2]);
            state <= S_CROSS;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_CROSS: begin
          if (step != 4'd0) begin
            nsum[acc_j[3:2]] <= acc_j[0] ? nsum[acc_j[3:2]] - prod
                                         : nsum[acc_j[3:2]] + prod;
          end
          if (step == 4'd12) begin
            state <= S_ABS;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= nsum[i] < 0;
            mag[i] <= (nsum[i] < 0) ? NSUM_W'(-nsum[i]) : NSUM_W'(nsum[i]);
          end
          state <= S_NORM;
        end
        S_NORM: begin
          // bring the largest magnitude into [2^30, 2^31)
          if (mor == '0) begin
            res.degenerate <= 1'b1;
            state <= S_DONE;
          end else if (|mor[NSUM_W-1:31]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!mor[30]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            step  <= '0;
            sum   <= '0;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (step != 4'd0) begin
            sum <= sum + mul_p;
          end
          if (step == 4'd3) begin
            rad   <= sum + mul_p;
            srem  <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_SQRT: begin
          if (st >= strial) begin
            srem <= 34'(st - strial);
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= st[33:0];
            root <= {root[30:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            di    <= '0;
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          drem  <= {1'b0, dn_init[45:15]};
          dnum  <= dn_init[14:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          drem <= qbit ? 32'(dr - {1'b0, root}) : dr[31:0];
          dnum <= dnum << 1;
          quo  <= qn;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd14) begin
            case (di)
              2'd0:    res.norm_x <= qv;
              2'd1:    res.norm_y <= qv;
              default: res.norm_z <= qv;
            endcase
            if (di == 2'd2) begin
              state <= S_DONE;
            end else begin
              di    <= di + 2'd1;
              state <= S_DIVS;
            end
          end
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/wrapped_heightfield_vertex_normal.sv @@
// ----------------------------------------------------------------------------
// wrapped_heightfield_vertex_normal
// toroidal displacement grid with per-vertex position and normal queries
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): op 0 writes one grid point at (col, row)
// and does not raise in_stall. op 1 queries a patch vertex and yields one
// output transaction.
// A query runs on one sequencer with one 32x32 multiplier: grid reads, cross
// products, normalizing shifts, squares, a square root and three divisions,
// in that order; the square root and the divisions take most of its time.
// in_stall is high for the whole query.
// Output channel (out_valid / out_stall): a result sits in an output register;
// the next item is accepted while it waits, and a finished query holds in the
// core until the register frees up.
// The APB port sets patch_size, patch_col and patch_row; the user writes them
// only while idle, which the block does not enforce. Reset clears control
// state and the registers to 16, 0, 0; grid contents are undefined until
// written, and no clearing pass is run.
module wrapped_heightfield_vertex_normal import hvn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic [6:0]               col,
  input  logic [6:0]               row,
  input  logic signed [DISP_W-1:0] disp_x,
  input  logic signed [DISP_W-1:0] disp_y,
  input  logic signed [DISP_W-1:0] disp_z,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [NORM_W-1:0] norm_x,
  output logic signed [NORM_W-1:0] norm_y,
  output logic signed [NORM_W-1:0] norm_z,
  output logic                     degenerate,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t cfg;
  res_t res;
  logic core_ready, res_valid, res_ready, start;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.patch_size <= 7'd16;
      cfg.patch_col  <= '0;
      cfg.patch_row  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_PATCH_SIZE: cfg.patch_size <= pwdata[6:0];
        REG_PATCH_COL:  cfg.patch_col  <= pwdata[7:0];
        REG_PATCH_ROW:  cfg.patch_row  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      REG_PATCH_SIZE: prdata = {25'b0, cfg.patch_size};
      REG_PATCH_COL:  prdata = 32'(cfg.patch_col);
      REG_PATCH_ROW:  prdata = 32'(cfg.patch_row);
      default:        prdata = '0;
    endcase
  end

  assign in_stall = !core_ready;
  assign start    = in_valid && core_ready;

  hvn_core u_core (
    .clk, .rst, .start, .op, .col, .row, .disp_x, .disp_y, .disp_z,
    .cfg, .ready(core_ready), .res_valid, .res_ready, .res
  );

  // output register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid  <= 1'b1;
      pos_x      <= res.pos_x;
      pos_y      <= res.pos_y;
      pos_z      <= res.pos_z;
      norm_x     <= res.norm_x;
      norm_y     <= res.norm_y;
      norm_z     <= res.norm_z;
      degenerate <= res.degenerate;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // a query keeps the input side busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op |=> in_stall)
    else $error("query accepted but input not stalled");

  // a grid write does not stall the input
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !op |=> !in_stall)
    else $error("grid write held the input");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("degenerate result with nonzero normal");

  // x and z normal components stay within unit range
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_x <= 16'sd16384 && norm_x >= -16'sd16384
               && norm_z <= 16'sd16384 && norm_z >= -16'sd16384)
    else $error("normal component out of range");

endmodule
